// ----- design/tesp_pkg.sv -----
// Package for the tree entry stream parser: payload types, codes and sizes.
`timescale 1ns / 1ps
`default_nettype none
package tesp_pkg;

    localparam int DIGEST_BYTES = 20;
    localparam int MODE_DIGITS  = 6;
    localparam int OCT_BITS     = 3;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int DIGEST_W = 5;
    localparam int ENTRY_W  = 10;
    localparam int MODE_W   = 18;
    localparam int STATUS_W = 2;
    localparam int DC_W     = $clog2(MODE_DIGITS + 1);

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [ENTRY_W-1:0] MAX_ENTRIES_RESET = ENTRY_W'(1000);

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

    localparam logic [KIND_W-1:0] KIND_PATH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIGEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MODE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        PH_MODE,
        PH_PATH,
        PH_DIGEST,
        PH_HALT
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_request;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   byte_value;
        logic [DIGEST_W-1:0] digest_index;
        logic [ENTRY_W-1:0]  entry_index;
        logic [MODE_W-1:0]   mode;
        logic                entry_done;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    // Up to two results written into the result queue in the same cycle.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage
`default_nettype wire

// ----- design/tesp_cfg.sv -----
// APB register block holding the entry limit.
`timescale 1ns / 1ps
`default_nettype none
module tesp_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tesp_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tesp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tesp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [tesp_pkg::ENTRY_W-1:0]      o_max_entries
);
    import tesp_pkg::*;

    logic [ENTRY_W-1:0] r_max_entries;
    logic               wr_en;

    // Single word register: byte offset bits carry no decode.
    assign wr_en  = psel & penable & pwrite & pready & (paddr[1:0] == 2'b00 | 1'b1);
    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-ENTRY_W){1'b0}}, r_max_entries};
    assign o_max_entries = r_max_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RESET;
        end else if (wr_en) begin
            r_max_entries <= pwdata[ENTRY_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- design/tesp_parse.sv -----
// Byte parser: phase state, mode accumulation and result generation.
`timescale 1ns / 1ps
`default_nettype none
module tesp_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire tesp_pkg::t_request            i_request,
    input  wire logic [tesp_pkg::ENTRY_W-1:0]  i_max_entries,
    output tesp_pkg::t_push                    o_push
);
    import tesp_pkg::*;

    t_phase              r_phase,  n_phase, eff_phase;
    logic [MODE_W-1:0]   r_acc,    n_acc;
    logic [DC_W-1:0]     r_dc,     n_dc;
    logic [DIGEST_W-1:0] r_dcnt,   n_dcnt;
    logic [ENTRY_W-1:0]  r_ec,     n_ec;
    logic [STATUS_W-1:0] r_err,    n_err;

    logic [BYTE_W-1:0]   b;
    logic                fin;
    logic                is_octal;
    logic                digest_last;
    logic                data_emit;
    logic [STATUS_W-1:0] rep_status;
    t_result             data_res;
    t_result             rep_res;

    assign b   = i_request.data_byte;
    assign fin = i_request.last_byte;

    // Halt at the start of an entry once the limit is reached.
    assign eff_phase = (r_phase == PH_MODE && r_dc == '0 && r_err == ST_OK &&
                        r_ec >= i_max_entries) ? PH_HALT : r_phase;

    assign digest_last = (r_dcnt >= DIGEST_W'(DIGEST_BYTES - 1));

    always_comb begin
        is_octal = b inside {[CHAR_ZERO:CHAR_SEVEN]};
    end

    // Next state.
    always_comb begin
        n_phase = eff_phase;
        n_acc   = r_acc;
        n_dc    = r_dc;
        n_dcnt  = r_dcnt;
        n_ec    = r_ec;
        n_err   = r_err;
        case (eff_phase)
            PH_MODE: begin
                if (is_octal && r_dc < DC_W'(MODE_DIGITS)) begin
                    n_acc = {r_acc[MODE_W-OCT_BITS-1:0], b[OCT_BITS-1:0]};
                    n_dc  = r_dc + 1'b1;
                end else if (b == CHAR_SPACE && r_dc != '0) begin
                    n_phase = PH_PATH;
                end else if (b == CHAR_NUL) begin
                    n_err   = ST_MODE;
                    n_phase = PH_HALT;
                end else begin
                    n_err   = ST_MODE;
                    n_phase = PH_PATH;
                end
            end
            PH_PATH: begin
                if (b == CHAR_NUL) begin
                    if (r_err == ST_MODE) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_phase = PH_DIGEST;
                        n_dcnt  = '0;
                    end
                end
            end
            PH_DIGEST: begin
                if (digest_last) begin
                    n_ec    = r_ec + 1'b1;
                    n_acc   = '0;
                    n_dc    = '0;
                    n_dcnt  = '0;
                    n_phase = PH_MODE;
                end else begin
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            PH_HALT: begin
                if (r_err == ST_OK) begin
                    n_err = ST_LIMIT;
                end
            end
            default: begin
                n_phase = PH_MODE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        data_emit = (eff_phase == PH_DIGEST) ||
                    (eff_phase == PH_PATH && b != CHAR_NUL && r_err == ST_OK);

        case (n_phase)
            PH_HALT:   rep_status = n_err;
            PH_DIGEST: rep_status = ST_TRUNC;
            default:   rep_status = ST_OK;
        endcase

        data_res.kind         = (eff_phase == PH_DIGEST) ? KIND_DIGEST : KIND_PATH;
        data_res.byte_value   = b;
        data_res.digest_index = (eff_phase == PH_DIGEST) ? r_dcnt : '0;
        data_res.entry_index  = r_ec;
        data_res.entry_done   = (eff_phase == PH_DIGEST) && digest_last;
        data_res.mode         = data_res.entry_done ? r_acc : '0;
        data_res.status       = ST_OK;
        data_res.last         = ~fin;

        rep_res.kind         = KIND_REPORT;
        rep_res.byte_value   = '0;
        rep_res.digest_index = '0;
        rep_res.entry_index  = n_ec;
        rep_res.mode         = '0;
        rep_res.entry_done   = 1'b0;
        rep_res.status       = rep_status;
        rep_res.last         = 1'b1;

        o_push.first  = data_emit ? data_res : rep_res;
        o_push.second = rep_res;
        o_push.count  = i_accept ? ({1'b0, data_emit} + {1'b0, fin}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MODE;
            r_acc   <= '0;
            r_dc    <= '0;
            r_dcnt  <= '0;
            r_ec    <= '0;
            r_err   <= ST_OK;
        end else if (i_accept) begin
            if (fin) begin
                r_phase <= PH_MODE;
                r_acc   <= '0;
                r_dc    <= '0;
                r_dcnt  <= '0;
                r_ec    <= '0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_dc    <= n_dc;
                r_dcnt  <= n_dcnt;
                r_ec    <= n_ec;
                r_err   <= n_err;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/tesp_outq.sv -----
// Three-entry result queue, two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tesp_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tesp_pkg::t_push    i_push,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output tesp_pkg::t_result       o_result,
    output logic [1:0]              o_count
);
    import tesp_pkg::*;

    t_result    r_mem [3];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic [1:0] wptr1;
    logic       pop;

    function automatic logic [1:0] wrap_inc(input logic [1:0] p);
        wrap_inc = (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rptr];
    assign o_count  = r_count;
    assign pop      = o_valid & i_ready;
    assign wptr1    = wrap_inc(r_wptr);

    always_comb begin
        n_rptr  = pop ? wrap_inc(r_rptr) : r_rptr;
        n_wptr  = (i_push.count == 2'd2) ? wrap_inc(wptr1) :
                  (i_push.count == 2'd1) ? wptr1 : r_wptr;
        n_count = r_count + i_push.count - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wptr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- design/tree_entry_stream_parser.sv -----
// Top level of the tree entry stream parser.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_request  (t_request)
//  result    out        o_out_valid / i_out_ready  o_result   (t_result)
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  Each request is parsed in the cycle it is accepted; its results land in a
//  three-entry result queue and can show on o_result from the next cycle on.
//  Throughput is one request per cycle while each request yields at most one
//  result and the result side keeps up; o_in_ready drops whenever two or more
//  results are queued, so a final byte that yields a data result and a report
//  holds off the next request. Reset (synchronous, active low) empties the
//  queue, returns the parser to the mode field and loads the entry limit with
//  1000. A stalled result side fills the queue and then holds o_in_ready low.
//
module tree_entry_stream_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tesp_pkg::t_request                i_request,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tesp_pkg::t_result                      o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tesp_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tesp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tesp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import tesp_pkg::*;

    logic [ENTRY_W-1:0] max_entries;
    logic               in_accept;
    logic               out_accept;
    logic [1:0]         q_count;
    t_push              push;

    // Take a request only when the queue has room for two results.
    assign o_in_ready = (q_count < 2'd2);
    assign in_accept  = i_in_valid & o_in_ready;
    assign out_accept = o_out_valid & i_out_ready;

    tesp_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_entries (max_entries)
    );

    // Advance the parse state and build the results of the accepted byte.
    tesp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_request     (i_request),
        .i_max_entries (max_entries),
        .o_push        (push)
    );

    // Hold results until the consumer takes them.
    tesp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (o_result),
        .o_count  (q_count)
    );

    // Entry end only on the final digest byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.entry_done) |->
        (o_result.kind == KIND_DIGEST &&
         o_result.digest_index == DIGEST_W'(DIGEST_BYTES - 1)))
        else $error("entry_done on a result that is not the last digest byte");

    // Status is only reported in end of stream results.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.kind != KIND_REPORT) |-> (o_result.status == ST_OK))
        else $error("nonzero status on a data result");

    // A report always closes the results of its request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.kind == KIND_REPORT) |-> o_result.last)
        else $error("report without last");

    // Queue occupancy moves only on a request or a result handshake.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_accept && !out_accept) |=> $stable(q_count))
        else $error("result queue occupancy changed without a handshake");

endmodule
`default_nettype wire

// ----- tb/tree_entry_stream_parser_test.sv -----
// Self-checking testbench for the tree entry stream parser: a directed table, then random bodies.
`timescale 1ns / 1ps
module tree_entry_stream_parser_test;
    import tesp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 17;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_ENTRIES = '0;

    // Directed table rows either send one body byte or rewrite the entry limit.
    typedef enum logic {
        ROW_BYTE,
        ROW_LIMIT
    } t_row_op;

    typedef struct {
        t_row_op            op;
        t_request           req;
        bit                 typed;
        t_result            want;
        logic [ENTRY_W-1:0] limit;
    } t_row;

    // Clock, reset and the two streaming channels.
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_request request   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_result  result;

    // Register port.
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the parser state and of the entry limit register.
    t_phase              parse_phase   = PH_MODE;
    logic [MODE_W-1:0]   mode_acc      = '0;
    logic [DC_W-1:0]     digit_count   = '0;
    logic [DIGEST_W-1:0] digest_pos    = '0;
    logic [ENTRY_W-1:0]  entries_done  = '0;
    logic [STATUS_W-1:0] stream_status = ST_OK;
    logic [ENTRY_W-1:0]  entry_limit   = MAX_ENTRIES_RESET;

    // Results the shadow parser has produced and the block has not yet delivered.
    t_result parsed_results[$];
    t_row    directed_plan[$];

    int mismatch_count = 0;
    // When set, neither side inserts idle cycles.
    bit quiet = 1'b0;

    tree_entry_stream_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_request  (request),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_result   (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result make_result(
        logic [KIND_W-1:0]   kind,
        logic [BYTE_W-1:0]   value,
        logic [DIGEST_W-1:0] dpos,
        logic [ENTRY_W-1:0]  entry,
        logic [MODE_W-1:0]   mode,
        logic                done,
        logic [STATUS_W-1:0] status,
        logic                last
    );
        t_result r;
        r.kind         = kind;
        r.byte_value   = value;
        r.digest_index = dpos;
        r.entry_index  = entry;
        r.mode         = mode;
        r.entry_done   = done;
        r.status       = status;
        r.last         = last;
        return r;
    endfunction

    // Advance the shadow parser by one body byte and queue the results it causes.
    task automatic parse_body_byte(input t_request req);
        logic [BYTE_W-1:0]   b;
        logic                fin;
        logic                entry_end;
        logic [STATUS_W-1:0] report_status;
        b   = req.data_byte;
        fin = req.last_byte;
        // Halt before a new entry once the limit is reached; a lowered limit counts too.
        if (parse_phase == PH_MODE && digit_count == 0 && stream_status == ST_OK &&
            entries_done >= entry_limit)
            parse_phase = PH_HALT;
        case (parse_phase)
            PH_MODE: begin
                if (b >= CHAR_ZERO && b <= CHAR_SEVEN && digit_count < MODE_DIGITS) begin
                    mode_acc    = (mode_acc << OCT_BITS) | MODE_W'(b - CHAR_ZERO);
                    digit_count = digit_count + 1'b1;
                end else if (b == CHAR_SPACE && digit_count != 0) begin
                    parse_phase = PH_PATH;
                end else if (b == CHAR_NUL) begin
                    // Zero byte inside the mode field confirms the bad mode at once.
                    stream_status = ST_MODE;
                    parse_phase   = PH_HALT;
                end else begin
                    // Bad mode: swallow the path, confirm on its zero byte.
                    stream_status = ST_MODE;
                    parse_phase   = PH_PATH;
                end
            end
            PH_PATH: begin
                if (b == CHAR_NUL) begin
                    if (stream_status == ST_MODE) begin
                        parse_phase = PH_HALT;
                    end else begin
                        parse_phase = PH_DIGEST;
                        digest_pos  = '0;
                    end
                end else if (stream_status == ST_OK) begin
                    parsed_results = {parsed_results,
                                      make_result(KIND_PATH, b, '0, entries_done, '0,
                                                  1'b0, ST_OK, !fin)};
                end
            end
            PH_DIGEST: begin
                entry_end = (digest_pos >= DIGEST_BYTES - 1);
                parsed_results = {parsed_results,
                                  make_result(KIND_DIGEST, b, digest_pos, entries_done,
                                              entry_end ? mode_acc : '0, entry_end,
                                              ST_OK, !fin)};
                if (entry_end) begin
                    entries_done = entries_done + 1'b1;
                    mode_acc     = '0;
                    digit_count  = '0;
                    digest_pos   = '0;
                    parse_phase  = PH_MODE;
                end else begin
                    digest_pos = digest_pos + 1'b1;
                end
            end
            default: begin
                // Halted: an ignored byte turns a clean stop into a limit report.
                if (stream_status == ST_OK)
                    stream_status = ST_LIMIT;
            end
        endcase
        if (fin) begin
            if (parse_phase == PH_HALT)
                report_status = stream_status;
            else if (parse_phase == PH_DIGEST)
                report_status = ST_TRUNC;
            else
                report_status = ST_OK;
            parsed_results = {parsed_results,
                              make_result(KIND_REPORT, '0, '0, entries_done, '0, 1'b0,
                                          report_status, 1'b1)};
            // End of body: return to the mode field, keep the limit.
            parse_phase   = PH_MODE;
            mode_acc      = '0;
            digit_count   = '0;
            digest_pos    = '0;
            entries_done  = '0;
            stream_status = ST_OK;
        end
    endtask

    task automatic compare_result(input t_result want, input t_result got);
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatch_count++;
        end
        if (got.byte_value !== want.byte_value) begin
            $error("byte_value: expected %0d, got %0d", want.byte_value, got.byte_value);
            mismatch_count++;
        end
        if (got.digest_index !== want.digest_index) begin
            $error("digest_index: expected %0d, got %0d", want.digest_index, got.digest_index);
            mismatch_count++;
        end
        if (got.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
            mismatch_count++;
        end
        if (got.mode !== want.mode) begin
            $error("mode: expected %0o, got %0o", want.mode, got.mode);
            mismatch_count++;
        end
        if (got.entry_done !== want.entry_done) begin
            $error("entry_done: expected %0d, got %0d", want.entry_done, got.entry_done);
            mismatch_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatch_count++;
        end
    endtask

    // Offer one request after a random gap, hold it until accepted, then predict.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic fin);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        request  <= '{data_byte: value, last_byte: fin};
        do @(posedge i_clk); while (!in_ready);
        parse_body_byte('{data_byte: value, last_byte: fin});
    endtask

    // Hold off requests until every queued result is out, then let the block settle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (parsed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the entry limit while idle, then read it back in a second transfer.
    task automatic write_entry_limit(input logic [ENTRY_W-1:0] value);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_ENTRIES;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        entry_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(entry_limit)) begin
            $error("max_entries: expected %0d, got %0d", entry_limit, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void plan_byte(logic [BYTE_W-1:0] value, logic fin);
        t_row row;
        row.op    = ROW_BYTE;
        row.req   = '{data_byte: value, last_byte: fin};
        row.typed = 1'b0;
        row.want  = '0;
        row.limit = '0;
        directed_plan = {directed_plan, row};
    endfunction

    // Final byte of a body whose end of stream report is known up front (entry 0).
    function automatic void plan_report(logic [BYTE_W-1:0] value, logic [STATUS_W-1:0] status);
        t_row row;
        row.op    = ROW_BYTE;
        row.req   = '{data_byte: value, last_byte: 1'b1};
        row.typed = 1'b1;
        row.want  = make_result(KIND_REPORT, '0, '0, '0, '0, 1'b0, status, 1'b1);
        row.limit = '0;
        directed_plan = {directed_plan, row};
    endfunction

    function automatic void plan_limit(logic [ENTRY_W-1:0] value);
        t_row row;
        row.op    = ROW_LIMIT;
        row.req   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.limit = value;
        directed_plan = {directed_plan, row};
    endfunction

    // Result side: take each result, check it against the oldest prediction, then stall.
    initial begin : result_sink
        int      stall;
        t_result want;
        wait (i_rst_n);
        out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_valid && out_ready) begin
                if (parsed_results.size() == 0) begin
                    $error("result kind %0d entry %0d arrived with nothing predicted",
                           result.kind, result.entry_index);
                    mismatch_count++;
                end else begin
                    want = parsed_results.pop_front();
                    compare_result(want, result);
                end
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tree_entry_stream_parser verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row              row;
        logic [BYTE_W-1:0] body[$];
        int                entries;
        int                cut;
        int                idx;
        int                items;

        // Zero byte where the mode should start: bad mode at once.
        plan_report(CHAR_NUL, ST_MODE);
        // Space with no digit before it, body ends in the path: dropped quietly.
        plan_report(CHAR_SPACE, ST_OK);
        // Short unterminated entry with extreme path bytes, two results on the last one.
        plan_byte(CHAR_ZERO + 8'd1, 1'b0);
        plan_byte(CHAR_SPACE, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h01, 1'b1);
        // One digit too many, confirmed by the zero byte.
        repeat (MODE_DIGITS + 1) plan_byte(CHAR_SEVEN, 1'b0);
        plan_report(CHAR_NUL, ST_MODE);
        // Non-octal digit just above '7'.
        plan_byte(CHAR_SEVEN + 8'd1, 1'b0);
        plan_report(CHAR_NUL, ST_MODE);
        // Body ends on the first digest byte.
        plan_byte(CHAR_ZERO + 8'd5, 1'b0);
        plan_byte(CHAR_SPACE, 1'b0);
        plan_byte(8'h70, 1'b0);
        plan_byte(CHAR_NUL, 1'b0);
        plan_report(8'hFF, ST_TRUNC);
        // Limit of zero: the first byte is already ignored.
        plan_limit('0);
        plan_report(8'h41, ST_LIMIT);
        plan_limit('1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.op == ROW_LIMIT) begin
                write_entry_limit(row.limit);
            end else begin
                send_byte(row.req.data_byte, row.req.last_byte);
                // Take the typed report in place of the predicted one.
                if (row.typed)
                    parsed_results[parsed_results.size() - 1] = row.want;
            end
        end

        // Random bodies: well-formed entries with random content, about half of them damaged.
        items = 0;
        while (items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_entry_limit('0);
                    1:       write_entry_limit(ENTRY_W'(1));
                    2:       write_entry_limit(ENTRY_W'(2));
                    3:       write_entry_limit('1);
                    4:       write_entry_limit(MAX_ENTRIES_RESET);
                    default: write_entry_limit(ENTRY_W'($urandom_range(0, 1023)));
                endcase
            end else if ($urandom_range(0, 4) == 0) begin
                wait_for_results();
            end

            body.delete();
            entries = $urandom_range(0, 3);
            repeat (entries) begin
                repeat ($urandom_range(1, MODE_DIGITS))
                    body = {body, CHAR_ZERO + BYTE_W'($urandom_range(0, 7))};
                body = {body, CHAR_SPACE};
                repeat ($urandom_range(0, 6)) body = {body, BYTE_W'($urandom_range(1, 255))};
                body = {body, CHAR_NUL};
                repeat (DIGEST_BYTES) body = {body, BYTE_W'($urandom_range(0, 255))};
            end
            case ($urandom_range(0, 9))
                0: begin
                    // Corrupt one byte anywhere.
                    if (body.size() > 0)
                        body[$urandom_range(0, body.size() - 1)] = BYTE_W'($urandom_range(0, 255));
                end
                1: begin
                    // Cut the body short.
                    if (body.size() > 1) begin
                        cut = $urandom_range(1, body.size() - 1);
                        while (body.size() > cut) void'(body.pop_back());
                    end
                end
                2: begin
                    // Append a tail with no terminator (or with one, by chance).
                    repeat ($urandom_range(1, 8)) body = {body, BYTE_W'($urandom_range(0, 255))};
                end
                3: begin
                    // Pure noise.
                    body.delete();
                    repeat ($urandom_range(1, 30)) body = {body, BYTE_W'($urandom_range(0, 255))};
                end
                4: begin
                    // Extra leading digit: overlong mode when the first one had six.
                    body.push_front(CHAR_ZERO + BYTE_W'($urandom_range(0, 7)));
                end
                default: ;
            endcase
            if (body.size() == 0)
                body = {body, BYTE_W'($urandom_range(0, 255))};

            for (idx = 0; idx < body.size(); idx++) begin
                // Now and then change the limit in the middle of a body.
                if ($urandom_range(0, 299) == 0)
                    write_entry_limit(ENTRY_W'($urandom_range(0, 3)));
                send_byte(body[idx], idx == body.size() - 1);
                // Count every byte offered, ignored ones included.
                items++;
            end
        end

        wait_for_results();
        if (mismatch_count == 0)
            $display("tree_entry_stream_parser verification clean");
        else
            $display("tree_entry_stream_parser verification failed");
        $finish;
    end

endmodule
